// ----- rtl/pid_closed_loop_step_top_assert.svh -----
// Assertion macros shared by the PID closed-loop step RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PID_CLOSED_LOOP_STEP_TOP_ASSERT_SVH
`define PID_CLOSED_LOOP_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pcls_pkg.sv -----
// Shared types, constants and command encoding for the PID closed-loop step.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pcls_pkg;

  // Fixed-point format of every value.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Coefficient register file.
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  // Sequencer: step 0 happens at the accepting edge, the rest follow.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = step_t'(15);

  // Register indexes of the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    IDX_PROP_GAIN     = 3'd0,
    IDX_INTEGRAL_COEF = 3'd1,
    IDX_DERIV_GAIN    = 3'd2,
    IDX_DERIV_FB1     = 3'd3,
    IDX_DERIV_FB2     = 3'd4,
    IDX_PLANT_POLE    = 3'd5,
    IDX_PLANT_GAIN    = 3'd6
  } reg_idx_e;

  // Operand selects shared by the multiplier and the saturating adder.
  typedef enum logic [3:0] {
    OPND_ZERO = 4'd0,
    OPND_REF  = 4'd1,
    OPND_E    = 4'd2,
    OPND_T    = 4'd3,
    OPND_U    = 4'd4,
    OPND_W    = 4'd5,
    OPND_V    = 4'd6,
    OPND_M    = 4'd7,
    OPND_IACC = 4'd8,
    OPND_EL   = 4'd9,
    OPND_EB   = 4'd10,
    OPND_DL   = 4'd11,
    OPND_DB   = 4'd12,
    OPND_PL   = 4'd13
  } opnd_e;

  // Destination of the adder result.
  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_E    = 3'd1,
    DST_T    = 3'd2,
    DST_U    = 3'd3,
    DST_W    = 3'd4,
    DST_V    = 3'd5
  } dst_e;

  // One datapath command per cycle.
  typedef struct packed {
    logic     mul_en;
    reg_idx_e mul_coef;
    opnd_e    mul_opnd;
    dst_e     alu_dst;
    opnd_e    alu_a;
    opnd_e    alu_b;
    logic     alu_sub;
    logic     commit;
  } cmd_t;

  localparam cmd_t CMD_NOP = '{
    mul_en:   1'b0,
    mul_coef: IDX_PROP_GAIN,
    mul_opnd: OPND_ZERO,
    alu_dst:  DST_NONE,
    alu_a:    OPND_ZERO,
    alu_b:    OPND_ZERO,
    alu_sub:  1'b0,
    commit:   1'b0
  };

  // Reset value of each coefficient register.
  function automatic logic signed [DATA_WIDTH-1:0] coef_reset(input reg_idx_e idx);
    logic signed [DATA_WIDTH-1:0] val;
    case (idx)
      IDX_PROP_GAIN:     val = DATA_WIDTH'(65536);
      IDX_INTEGRAL_COEF: val = DATA_WIDTH'(3277);
      IDX_DERIV_GAIN:    val = DATA_WIDTH'(1248305);
      IDX_DERIV_FB1:     val = DATA_WIDTH'(62415);
      IDX_DERIV_FB2:     val = DATA_WIDTH'(-31208);
      IDX_PLANT_POLE:    val = DATA_WIDTH'(59299);
      IDX_PLANT_GAIN:    val = DATA_WIDTH'(6237);
      default:           val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/pcls_ctrl.sv -----
// Sequencer for the PID closed-loop step: handshakes and per-cycle datapath commands.
// Depends on pcls_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pid_closed_loop_step_top_assert.svh"

module pcls_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pcls_pkg::cmd_t cmd_o
);
  import pcls_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q;
  step_t  step_q;
  logic   out_valid_q;
  logic   slot_free;
  cmd_t   cmd;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Command schedule. One multiply may issue per step; its product is registered
  // in prod_q, then rounded and saturated into m_q, where the adder reads it.
  always_comb begin
    cmd = CMD_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // e = reference - plant_state
          cmd.alu_dst = DST_E;
          cmd.alu_a   = OPND_REF;
          cmd.alu_b   = OPND_PL;
          cmd.alu_sub = 1'b1;
        end
      end
      S_RUN: begin
        case (step_q)
          4'd1: begin
            cmd.alu_dst = DST_T;
            cmd.alu_a   = OPND_EL;
            cmd.alu_b   = OPND_EL;
          end
          4'd2: begin
            cmd.alu_dst = DST_T;
            cmd.alu_a   = OPND_E;
            cmd.alu_b   = OPND_T;
            cmd.alu_sub = 1'b1;
          end
          4'd3: begin
            // T becomes the error second difference.
            cmd.alu_dst  = DST_T;
            cmd.alu_a    = OPND_T;
            cmd.alu_b    = OPND_EB;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_PROP_GAIN;
            cmd.mul_opnd = OPND_E;
          end
          4'd4: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_INTEGRAL_COEF;
            cmd.mul_opnd = OPND_E;
          end
          4'd5: begin
            cmd.alu_dst  = DST_U;
            cmd.alu_a    = OPND_ZERO;
            cmd.alu_b    = OPND_M;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_INTEGRAL_COEF;
            cmd.mul_opnd = OPND_EL;
          end
          4'd6: begin
            cmd.alu_dst  = DST_W;
            cmd.alu_a    = OPND_IACC;
            cmd.alu_b    = OPND_M;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_DERIV_GAIN;
            cmd.mul_opnd = OPND_T;
          end
          4'd7: begin
            cmd.alu_dst  = DST_W;
            cmd.alu_a    = OPND_W;
            cmd.alu_b    = OPND_M;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_DERIV_FB1;
            cmd.mul_opnd = OPND_DL;
          end
          4'd8: begin
            cmd.alu_dst  = DST_V;
            cmd.alu_a    = OPND_ZERO;
            cmd.alu_b    = OPND_M;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_DERIV_FB2;
            cmd.mul_opnd = OPND_DB;
          end
          4'd9: begin
            cmd.alu_dst = DST_V;
            cmd.alu_a   = OPND_V;
            cmd.alu_b   = OPND_M;
            cmd.alu_sub = 1'b1;
          end
          4'd10: begin
            cmd.alu_dst = DST_V;
            cmd.alu_a   = OPND_V;
            cmd.alu_b   = OPND_M;
            cmd.alu_sub = 1'b1;
          end
          4'd11: begin
            cmd.alu_dst  = DST_U;
            cmd.alu_a    = OPND_U;
            cmd.alu_b    = OPND_W;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_PLANT_POLE;
            cmd.mul_opnd = OPND_PL;
          end
          4'd12: begin
            cmd.alu_dst = DST_U;
            cmd.alu_a   = OPND_U;
            cmd.alu_b   = OPND_V;
          end
          4'd13: begin
            cmd.alu_dst  = DST_T;
            cmd.alu_a    = OPND_ZERO;
            cmd.alu_b    = OPND_M;
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = IDX_PLANT_GAIN;
            cmd.mul_opnd = OPND_U;
          end
          4'd15: begin
            // Final plant sum; commit only when the output register is free.
            if (slot_free) begin
              cmd.alu_a  = OPND_T;
              cmd.alu_b  = OPND_M;
              cmd.commit = 1'b1;
            end
          end
          default: begin
            cmd = CMD_NOP;
          end
        endcase
      end
      default: begin
        cmd = CMD_NOP;
      end
    endcase
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            step_q  <= step_t'(1);
          end
        end
        S_RUN: begin
          if (step_q != LAST_STEP) begin
            step_q <= step_q + step_t'(1);
          end else if (slot_free) begin
            state_q <= S_IDLE;
            step_q  <= '0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `PCLS_ASSERT_NEXT(a_accept_starts_run, in_valid_i && !in_stall_o, state_q == S_RUN && step_q == step_t'(1), "accepted transaction did not start the sequence")
  `PCLS_ASSERT_NOW(a_run_step_nonzero, state_q == S_RUN, step_q != '0, "sequencer running at step zero")
  `PCLS_ASSERT_NEXT(a_commit_sets_valid, cmd.commit, out_valid_q, "committed result not presented")
  `PCLS_ASSERT_NOW(a_commit_only_last, cmd.commit, state_q == S_RUN && step_q == LAST_STEP && slot_free, "commit outside the final step or into a full output register")

endmodule

// ----- rtl/pcls_dpath.sv -----
// Datapath for the PID closed-loop step: coefficients, loop state, one shared
// multiplier with rounding and saturation, and a saturating adder. Depends on pcls_pkg.
`timescale 1ns / 1ps

module pcls_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pcls_pkg::REG_IDX_W-1:0]         cfg_idx_i,
  input  logic signed [pcls_pkg::DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic signed [pcls_pkg::DATA_WIDTH-1:0] reference_i,
  input  pcls_pkg::cmd_t                         cmd_i,
  output logic signed [pcls_pkg::DATA_WIDTH-1:0] drive_o,
  output logic signed [pcls_pkg::DATA_WIDTH-1:0] plant_out_o
);
  import pcls_pkg::*;

  localparam int D       = DATA_WIDTH;
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int ROUND_W = 2 * DATA_WIDTH + 1 - FRAC_BITS;

  typedef logic signed [D-1:0] word_t;

  localparam word_t MAX_POS = {1'b0, {(D-1){1'b1}}};
  localparam word_t MIN_NEG = {1'b1, {(D-1){1'b0}}};

  // Coefficient registers.
  word_t coef_q [NUM_REGS];

  // Loop state carried between samples.
  word_t iacc_q, el_q, eb_q, dl_q, db_q, pl_q;

  // Work registers for one sample.
  word_t e_q, t_q, u_q, w_q, v_q;

  // Multiplier pipeline: magnitude product, then rounded and saturated value.
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  word_t             m_q;

  // Output register.
  word_t drive_q, plant_out_q;

  word_t             mul_a, mul_b, alu_a, alu_b, alu_res, m_d;
  logic [D-1:0]      mag_a, mag_b;
  logic [D:0]        sum;
  logic [PROD_W:0]   rnd;
  logic [ROUND_W-1:0] rmag, rlimit;
  logic [D-1:0]      rlow;

  function automatic word_t pick(input opnd_e sel, input word_t ref_v, input word_t e_v,
                                 input word_t t_v, input word_t u_v, input word_t w_v,
                                 input word_t v_v, input word_t m_v, input word_t iacc_v,
                                 input word_t el_v, input word_t eb_v, input word_t dl_v,
                                 input word_t db_v, input word_t pl_v);
    word_t r;
    case (sel)
      OPND_ZERO: r = '0;
      OPND_REF:  r = ref_v;
      OPND_E:    r = e_v;
      OPND_T:    r = t_v;
      OPND_U:    r = u_v;
      OPND_W:    r = w_v;
      OPND_V:    r = v_v;
      OPND_M:    r = m_v;
      OPND_IACC: r = iacc_v;
      OPND_EL:   r = el_v;
      OPND_EB:   r = eb_v;
      OPND_DL:   r = dl_v;
      OPND_DB:   r = db_v;
      OPND_PL:   r = pl_v;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Operand selection.
  always_comb begin
    mul_a = coef_q[cmd_i.mul_coef];
    mul_b = pick(cmd_i.mul_opnd, reference_i, e_q, t_q, u_q, w_q, v_q, m_q,
                 iacc_q, el_q, eb_q, dl_q, db_q, pl_q);
    alu_a = pick(cmd_i.alu_a, reference_i, e_q, t_q, u_q, w_q, v_q, m_q,
                 iacc_q, el_q, eb_q, dl_q, db_q, pl_q);
    alu_b = pick(cmd_i.alu_b, reference_i, e_q, t_q, u_q, w_q, v_q, m_q,
                 iacc_q, el_q, eb_q, dl_q, db_q, pl_q);
  end

  // Operand magnitudes; the most negative value maps to its true magnitude.
  assign mag_a = mul_a[D-1] ? (~mul_a + 1'b1) : mul_a;
  assign mag_b = mul_b[D-1] ? (~mul_b + 1'b1) : mul_b;

  // Saturating add or subtract in one extra bit.
  always_comb begin
    if (cmd_i.alu_sub) begin
      sum = {alu_a[D-1], alu_a} - {alu_b[D-1], alu_b};
    end else begin
      sum = {alu_a[D-1], alu_a} + {alu_b[D-1], alu_b};
    end
    if (sum[D] != sum[D-1]) begin
      alu_res = sum[D] ? MIN_NEG : MAX_POS;
    end else begin
      alu_res = sum[D-1:0];
    end
  end

  // Round the magnitude half away from zero, then saturate and restore the sign.
  always_comb begin
    rnd    = {1'b0, prod_q} + {{(PROD_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    rmag   = rnd[PROD_W:FRAC_BITS];
    rlimit = ROUND_W'(MAX_POS) + ROUND_W'(neg_q);
    rlow   = rmag[D-1:0];
    if (rmag > rlimit) begin
      m_d = neg_q ? MIN_NEG : MAX_POS;
    end else begin
      m_d = neg_q ? (~rlow + 1'b1) : rlow;
    end
  end

  // Coefficient register writes; indexes past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= coef_reset(reg_idx_e'(i));
      end
    end else if (cfg_we_i && (cfg_idx_i < REG_IDX_W'(NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Loop state is updated only when a sample commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iacc_q <= '0;
      el_q   <= '0;
      eb_q   <= '0;
      dl_q   <= '0;
      db_q   <= '0;
      pl_q   <= '0;
    end else if (cmd_i.commit) begin
      iacc_q <= w_q;
      eb_q   <= el_q;
      el_q   <= e_q;
      db_q   <= dl_q;
      dl_q   <= v_q;
      pl_q   <= alu_res;
    end
  end

  // Work registers, multiplier pipeline and output register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.alu_dst)
      DST_E:   e_q <= alu_res;
      DST_T:   t_q <= alu_res;
      DST_U:   u_q <= alu_res;
      DST_W:   w_q <= alu_res;
      DST_V:   v_q <= alu_res;
      default: begin
      end
    endcase

    if (cmd_i.mul_en) begin
      prod_q <= mag_a * mag_b;
      neg_q  <= mul_a[D-1] ^ mul_b[D-1];
    end
    m_q <= m_d;

    if (cmd_i.commit) begin
      drive_q     <= u_q;
      plant_out_q <= alu_res;
    end
  end

  assign drive_o     = drive_q;
  assign plant_out_o = plant_out_q;

endmodule

// ----- rtl/pid_closed_loop_step_top.sv -----
// PID closed-loop step, top level. An input transaction carries one reference
// sample; the block returns the controller drive and the new modelled plant
// output, both signed Q16.16 with saturation. Each sample runs through a
// fixed 16-step schedule on one shared 32x32 multiplier (a product register
// followed by a rounded and saturated register) and one saturating adder; a
// new sample is accepted only after the previous one has left the schedule.
// The output is registered: the next sample is accepted while a result still
// waits, but it cannot finish until that result has been taken. Coefficients
// must be written by the user through the cfg port only while the block is
// idle, unenforced by the block. Depends on pcls_pkg, pcls_ctrl, pcls_dpath.
`timescale 1ns / 1ps

module pid_closed_loop_step_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pcls_pkg::REG_IDX_W-1:0]         cfg_idx_i,
  input  logic signed [pcls_pkg::DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pcls_pkg::DATA_WIDTH-1:0] reference_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pcls_pkg::DATA_WIDTH-1:0] drive_o,
  output logic signed [pcls_pkg::DATA_WIDTH-1:0] plant_out_o
);
  import pcls_pkg::*;

  cmd_t cmd;

  // Sequencer and handshakes.
  pcls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic, coefficients and loop state.
  pcls_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .reference_i (reference_i),
    .cmd_i       (cmd),
    .drive_o     (drive_o),
    .plant_out_o (plant_out_o)
  );

endmodule
